@@ rtl/hsb_pkg.sv @@
`default_nettype none

package hsb_pkg;

  typedef enum logic [2:0] {
    OP_DRAW  = 3'd0,
    OP_XOR   = 3'd1,
    OP_UNSET = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic RES_SPRITE = 1'b0;
  localparam logic RES_READ   = 1'b1;

  localparam int SCREEN_ROWS = 192;
  localparam int ROW_BYTES   = 40;
  localparam int ADDR_W      = 13;

  localparam logic [13:0] ROW_STEP   = 14'h0400;
  localparam logic [13:0] GROUP_STEP = 14'h0080;
  localparam logic [13:0] BAND_STEP  = 14'h0028;

  // one frame memory access on its way to the write-back stage
  typedef struct packed {
    logic              valid;
    logic              res;
    op_t               op;
    logic              inr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        val;
  } slot_t;

  typedef struct packed {
    logic       kind;
    logic       collision;
    logic [7:0] data;
  } result_t;

  // interleaved scanline start offset
  function automatic logic [13:0] line_base(input logic [7:0] row);
    return 14'(row[2:0]) * ROW_STEP + 14'(row[5:3]) * GROUP_STEP
         + 14'(row[7:6]) * BAND_STEP;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hires_sprite_blitter.sv @@
// Hires sprite blitter: an interleaved bitmap frame memory of FRAME_BYTES bytes, 7 pixels per
// byte, into which sprite bytes are drawn, xored, erased or cleared; op read returns one byte.
// After reset a clearing pass writes zero to the whole memory, one byte a cycle, so no item is
// taken until it is done. An item that ends a row or the sprite makes a second access, for its
// left-over pixels, before it is taken; each frame memory access (one read and one write-back)
// uses the single read port and single write port of the memory once. A result is registered
// in the write-back stage, then in the result buffer, which is four deep, so apart from the
// clearing pass and second accesses the input stalls only when result items are not taken.
`default_nettype none

module hires_sprite_blitter #(
  parameter int FRAME_BYTES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // x_pos[7:0], y_pos[15:8], sprite_byte[23:16], row_end[24], read_address[37:25]
  input  wire logic [39:0] in_tdata,
  // op[2:0]
  input  wire logic [2:0]  in_tuser,
  // sprite_end
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // collision[0], read_data[8:1]
  output logic [15:0]      out_tdata,
  // result_kind[0]
  output logic             out_tuser
);

  localparam int AW = $clog2(FRAME_BYTES);

  hsb_pkg::op_t    in_op;
  logic [7:0]      x_pos, y_pos, sprite_byte;
  logic [12:0]     read_address;
  logic            row_end, sprite_end;

  assign in_op        = hsb_pkg::op_t'(in_tuser);
  assign x_pos        = in_tdata[7:0];
  assign y_pos        = in_tdata[15:8];
  assign sprite_byte  = in_tdata[23:16];
  assign row_end      = in_tdata[24];
  assign read_address = in_tdata[37:25];
  assign sprite_end   = in_tlast;

  logic [7:0]       frame_mem_r [FRAME_BYTES];
  logic [7:0]       rd_data_r;
  logic             clr_r;
  logic [AW-1:0]    clr_addr_r;

  logic             phase_r, phase_nxt;
  logic [7:0]       col_cnt_r, col_cnt_nxt;
  logic [7:0]       row_cnt_r, row_cnt_nxt;
  logic [6:0]       left_r, left_nxt;
  logic             ov_r, ov_nxt;

  hsb_pkg::slot_t   slot, s2_r;
  logic             lw_valid_r;
  logic [12:0]      lw_addr_r;
  logic [7:0]       lw_data_r;

  hsb_pkg::result_t fifo_r [4];
  logic [1:0]       wptr_r, rptr_r;
  logic [2:0]       fifo_cnt_r;

  // issue side
  logic             op_ok, is_read, two, slot_res, stall, go;
  logic [2:0]       pend;
  logic [16:0]      prod;
  logic [5:0]       xb;
  logic [7:0]       rem8;
  logic [2:0]       xs;
  logic [8:0]       row, col;
  logic [14:0]      shifted;
  logic [7:0]       merged, right;
  logic [6:0]       new_left;
  logic [13:0]      addr_full;
  logic             draw_inr;

  assign op_ok    = in_op inside {hsb_pkg::OP_DRAW, hsb_pkg::OP_XOR, hsb_pkg::OP_UNSET,
                                  hsb_pkg::OP_CLEAR, hsb_pkg::OP_READ};
  assign is_read  = in_op == hsb_pkg::OP_READ;
  assign two      = !is_read && (row_end || sprite_end);
  assign slot_res = is_read || (phase_r && sprite_end);
  assign pend     = fifo_cnt_r + 3'(s2_r.valid && s2_r.res);
  assign stall    = slot_res && (pend >= 3'd4);
  assign go       = in_tvalid && !clr_r && op_ok && !stall;
  assign in_tready = !clr_r && (!op_ok || (!stall && (!two || phase_r)));

  // x / 7 by reciprocal, exact for 8-bit x
  assign prod     = 17'(x_pos) * 17'd293;
  assign xb       = prod[16:11];
  assign rem8     = x_pos - 8'(9'(xb) * 9'd7);
  assign xs       = rem8[2:0];

  assign row      = 9'(y_pos) + 9'(row_cnt_r);
  assign col      = 9'(xb) + 9'(col_cnt_r);
  assign shifted  = 15'(sprite_byte) << xs;
  assign merged   = shifted[7:0] | {1'b0, left_r};
  assign right    = sprite_byte >> (3'd7 - xs);
  assign new_left = right[6:0];
  assign addr_full = hsb_pkg::line_base(row[7:0]) + 14'(col);
  assign draw_inr = (row < 9'(hsb_pkg::SCREEN_ROWS)) && (col < 9'(hsb_pkg::ROW_BYTES))
                 && (addr_full < 14'(FRAME_BYTES));

  always_comb begin
    slot.valid = go;
    slot.res   = slot_res;
    slot.op    = in_op;
    if (is_read) begin
      slot.inr  = 14'(read_address) < 14'(FRAME_BYTES);
      slot.addr = read_address;
      slot.val  = 8'd0;
    end else begin
      slot.inr  = draw_inr;
      slot.addr = addr_full[12:0];
      slot.val  = phase_r ? {1'b0, left_r} : merged;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    left_nxt    = left_r;
    if (go && !is_read) begin
      if (!phase_r) begin
        left_nxt    = new_left;
        col_cnt_nxt = (col_cnt_r == 8'hff) ? col_cnt_r : col_cnt_r + 8'd1;
        phase_nxt   = two;
      end else begin
        left_nxt    = 7'd0;
        col_cnt_nxt = 8'd0;
        row_cnt_nxt = sprite_end ? 8'd0 :
                      ((row_cnt_r == 8'hff) ? row_cnt_r : row_cnt_r + 8'd1);
        phase_nxt   = 1'b0;
      end
    end
  end

  // write-back side
  logic [7:0]       old, new_val;
  logic             hit, wr, push, pop;
  hsb_pkg::result_t res_d;

  assign old = (lw_valid_r && lw_addr_r == s2_r.addr) ? lw_data_r : rd_data_r;

  always_comb begin
    case (s2_r.op)
      hsb_pkg::OP_DRAW:  new_val = s2_r.val;
      hsb_pkg::OP_XOR:   new_val = old ^ s2_r.val;
      hsb_pkg::OP_UNSET: new_val = old & ~s2_r.val;
      default:           new_val = 8'd0;
    endcase
  end

  assign hit  = (s2_r.op == hsb_pkg::OP_XOR) && s2_r.inr && |(old & s2_r.val);
  assign wr   = s2_r.valid && s2_r.inr && (s2_r.op != hsb_pkg::OP_READ);
  assign push = s2_r.valid && s2_r.res;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    if (s2_r.op == hsb_pkg::OP_READ) begin
      res_d.kind      = hsb_pkg::RES_READ;
      res_d.collision = 1'b0;
      res_d.data      = s2_r.inr ? old : 8'd0;
    end else begin
      res_d.kind      = hsb_pkg::RES_SPRITE;
      res_d.collision = ov_r || hit;
      res_d.data      = 8'd0;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (s2_r.valid && s2_r.op != hsb_pkg::OP_READ) begin
      ov_nxt = s2_r.res ? 1'b0 : (ov_r || hit);
    end
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (clr_r) begin
      frame_mem_r[clr_addr_r] <= 8'd0;
    end else if (wr) begin
      frame_mem_r[s2_r.addr[AW-1:0]] <= new_val;
    end
    rd_data_r <= frame_mem_r[slot.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      phase_r    <= 1'b0;
      col_cnt_r  <= 8'd0;
      row_cnt_r  <= 8'd0;
      left_r     <= 7'd0;
      ov_r       <= 1'b0;
      s2_r.valid <= 1'b0;
      lw_valid_r <= 1'b0;
      wptr_r     <= 2'd0;
      rptr_r     <= 2'd0;
      fifo_cnt_r <= 3'd0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(FRAME_BYTES - 1)) begin
          clr_r <= 1'b0;
        end
      end
      phase_r    <= phase_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      left_r     <= left_nxt;
      ov_r       <= ov_nxt;
      s2_r       <= slot;
      lw_valid_r <= wr;
      if (push) begin
        wptr_r <= wptr_r + 2'd1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
      fifo_cnt_r <= fifo_cnt_r + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r <= s2_r.addr;
    lw_data_r <= new_val;
    if (push) begin
      fifo_r[wptr_r] <= res_d;
    end
  end

  assign out_tvalid = fifo_cnt_r != 3'd0;
  assign out_tdata  = {7'd0, fifo_r[rptr_r].data, fifo_r[rptr_r].collision};
  assign out_tuser  = fifo_r[rptr_r].kind;

endmodule

`default_nettype wire
